### hw/rtl/rdi_pkg.sv
package rdi_pkg;

	localparam int unsigned COLUMNS_DEF    = 20;
	localparam int unsigned MAX_UNIQUE_DEF = 64;
	localparam int unsigned WORD_W         = 32;
	localparam int unsigned ID_W           = 6;

	localparam logic [WORD_W-1:0] ABS_MASK     = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] EXP_ALL_ONES = 32'h7F80_0000;

	// Per-transaction control broadcast to every cell
	typedef struct packed {
		logic acc;     // input transaction this cycle
		logic clr;     // start of sequence, store emptied first
		logic last;    // word closes the row
		logic commit;  // row matched nothing and store not full, store it
	} rdi_ctl_t;

	// IEEE single equality: NaN never equal, +0 == -0
	function automatic logic words_equal(input logic [WORD_W-1:0] a,
		input logic [WORD_W-1:0] b);
		logic a_nan;
		logic b_nan;
		a_nan = (a & ABS_MASK) > EXP_ALL_ONES;
		b_nan = (b & ABS_MASK) > EXP_ALL_ONES;
		if (a_nan || b_nan) begin
			return 1'b0;
		end
		if (((a | b) & ABS_MASK) == '0) begin
			return 1'b1;
		end
		return a == b;
	endfunction

endpackage

### hw/rtl/rdi_cell.sv
// One stored row with its match flag and occupancy.
module rdi_cell #(
	parameter int unsigned COLUMNS = rdi_pkg::COLUMNS_DEF,
	localparam int unsigned CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rdi_pkg::rdi_ctl_t             ctl,
	input  logic [CW-1:0]                 col,
	input  logic [rdi_pkg::WORD_W-1:0]    word,
	input  logic                          prev_occ,
	output logic                          occ,
	output logic                          hit
);

	logic [rdi_pkg::WORD_W-1:0] row_q [COLUMNS];
	logic occ_q;
	logic flag_q;
	logic flag_eff;
	logic eq;
	logic take;

	assign occ      = occ_q & ~ctl.clr;
	assign flag_eff = ctl.clr | flag_q;
	assign eq       = rdi_pkg::words_equal(word, row_q[col]);
	assign take     = ~occ & prev_occ;   // first free cell in the chain
	assign hit      = occ & flag_eff & eq;

	always_ff @(posedge clk) begin
		if (ctl.acc && take) begin
			row_q[col] <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= 1'b0;
			flag_q <= 1'b1;
		end else if (ctl.acc) begin
			occ_q  <= occ | (ctl.commit & take);
			flag_q <= ctl.last ? 1'b1 : (flag_eff & eq);
		end
	end

endmodule

### hw/rtl/row_dedup_id_assigner.sv
// Latency: result valid the cycle after the transaction carrying a row's last word.
// Throughput: one word per cycle; input stalls only while a result waits unread.
// Every stored row sits in its own cell and compares the broadcast word in parallel.
// Reset: arst_n clears occupancy, column and output valid and sets match flags; row words
// need no reset since a cell is read only once occupied.
module row_dedup_id_assigner #(
	parameter int unsigned COLUMNS    = rdi_pkg::COLUMNS_DEF,
	parameter int unsigned MAX_UNIQUE = rdi_pkg::MAX_UNIQUE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] word
	input  logic        s_tuser,   // [0] new_sequence
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [5:0] block_id, [6] is_new, [7] table_full
);

	localparam int unsigned CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int unsigned IW = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;

	rdi_pkg::rdi_ctl_t ctl;
	logic [CW-1:0] col_q;
	logic [CW-1:0] col_eff;
	logic [MAX_UNIQUE:0] occ_chain;  // occ_chain[k] feeds cell k; [0] tied high
	logic [MAX_UNIQUE-1:0] hit;
	logic any_hit;
	logic [IW-1:0] hit_id;
	logic [IW-1:0] new_id;
	logic full;

	logic out_valid_q;
	logic [rdi_pkg::ID_W-1:0] out_id_q;
	logic out_new_q;
	logic out_full_q;

	// Accept whenever the result slot is free or draining this cycle
	assign s_tready = ~out_valid_q | m_tready;

	assign ctl.acc    = s_tvalid & s_tready;
	assign ctl.clr    = s_tuser;
	assign col_eff    = ctl.clr ? '0 : col_q;
	assign ctl.last   = (col_eff == CW'(COLUMNS - 1));
	assign ctl.commit = ctl.last & ~any_hit & ~full;

	assign occ_chain[0] = 1'b1;

	for (genvar k = 0; k < MAX_UNIQUE; k++) begin : g_cell
		rdi_cell #(.COLUMNS(COLUMNS)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.col      (col_eff),
			.word     (s_tdata),
			.prev_occ (occ_chain[k]),
			.occ      (occ_chain[k+1]),
			.hit      (hit[k])
		);
	end

	assign full    = occ_chain[MAX_UNIQUE];
	assign any_hit = |hit;

	// Stored rows are pairwise unequal, so at most one cell hits: OR-encode
	always_comb begin
		hit_id = '0;
		new_id = '0;
		for (int k = 0; k < MAX_UNIQUE; k++) begin
			if (hit[k]) begin
				hit_id = hit_id | IW'(k);
			end
			if (occ_chain[k] && !occ_chain[k+1]) begin
				new_id = new_id | IW'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (ctl.acc) begin
			col_q <= ctl.last ? '0 : CW'(col_eff + 1'b1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.acc && ctl.last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc && ctl.last) begin
			out_new_q  <= ~any_hit & ~full;
			out_full_q <= ~any_hit & full;
			if (any_hit) begin
				out_id_q <= rdi_pkg::ID_W'(hit_id);
			end else if (full) begin
				out_id_q <= '0;
			end else begin
				out_id_q <= rdi_pkg::ID_W'(new_id);
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_full_q, out_new_q, out_id_q};

	// Checks; a prefix may match several rows, a whole row only one
	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.acc && ctl.last) |-> $onehot0(hit))
		else $error("more than one stored row matched");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[6] && m_tdata[7]))
		else $error("is_new and table_full both set");

	a_full_id: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[7]) |-> (m_tdata[5:0] == '0))
		else $error("table_full with nonzero id");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result dropped while stalled");

endmodule

### test/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned N_COLS     = rdi_pkg::COLUMNS_DEF;
	localparam int unsigned N_UNIQUE   = rdi_pkg::MAX_UNIQUE_DEF;
	localparam int unsigned CYCLE_CAP  = 2000000;
	localparam logic [31:0] POS_ZERO   = 32'h0000_0000;
	localparam logic [31:0] NEG_ZERO   = 32'h8000_0000;
	localparam logic [31:0] QNAN       = 32'h7FC0_0000;
	localparam logic [31:0] POS_INF    = 32'h7F80_0000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] word
	logic        s_tuser;   // [0] new_sequence
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [5:0] block_id, [6] is_new, [7] table_full

	// one expected row outcome
	typedef struct packed {
		logic [rdi_pkg::ID_W-1:0] block_id;
		logic                     is_new;
		logic                     table_full;
	} row_outcome_t;

	row_outcome_t outcome_q[$];
	int unsigned  n_errors;
	int unsigned  n_cycles;
	int unsigned  stall_left;

	// shadow of the dedup store
	logic [31:0] shadow_rows [N_UNIQUE][N_COLS];
	logic [31:0] shadow_pending [N_COLS];
	int unsigned shadow_count;
	int unsigned shadow_col;
	bit          shadow_match [N_UNIQUE];

	row_dedup_id_assigner i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		n_cycles <= n_cycles + 1;
		if (n_cycles > CYCLE_CAP) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic bit is_nan(logic [31:0] w);
		return (w & 32'h7FFF_FFFF) > 32'h7F80_0000;
	endfunction

	function automatic bit fp_eq(logic [31:0] a, logic [31:0] b);
		if (is_nan(a) || is_nan(b)) return 1'b0;
		if (((a | b) & 32'h7FFF_FFFF) == 0) return 1'b1;
		return a == b;
	endfunction

	// advance the shadow by one accepted word; push an outcome on a row end
	task automatic track_word(input logic [31:0] w, input logic start);
		row_outcome_t o;
		bit hit;
		if (start) begin
			shadow_count = 0;
			shadow_col = 0;
			foreach (shadow_match[k]) shadow_match[k] = 1'b1;
		end
		shadow_pending[shadow_col] = w;
		for (int k = 0; k < shadow_count; k++)
			if (!fp_eq(w, shadow_rows[k][shadow_col])) shadow_match[k] = 1'b0;
		shadow_col++;
		if (shadow_col < N_COLS) return;
		o = '0;
		hit = 1'b0;
		for (int k = 0; k < shadow_count; k++)
			if (!hit && shadow_match[k]) begin
				hit = 1'b1;
				o.block_id = k[rdi_pkg::ID_W-1:0];
			end
		if (!hit) begin
			if (shadow_count < N_UNIQUE) begin
				foreach (shadow_pending[c]) shadow_rows[shadow_count][c] = shadow_pending[c];
				o.block_id = shadow_count[rdi_pkg::ID_W-1:0];
				o.is_new = 1'b1;
				shadow_count++;
			end else begin
				o.table_full = 1'b1;
			end
		end
		shadow_col = 0;
		foreach (shadow_match[k]) shadow_match[k] = 1'b1;
		outcome_q.push_back(o);
	endtask

	// result checker and random backpressure, mostly short stalls and a few long
	always @(posedge clk) begin
		row_outcome_t exp_o;
		row_outcome_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.block_id   = m_tdata[5:0];
				got.is_new     = m_tdata[6];
				got.table_full = m_tdata[7];
				if (outcome_q.size() == 0) begin
					$error("unexpected result transaction %h", m_tdata);
					n_errors++;
				end else begin
					exp_o = outcome_q.pop_front();
					if (got.block_id != exp_o.block_id) begin
						$error("block_id expected %0d actual %0d", exp_o.block_id, got.block_id);
						n_errors++;
					end
					if (got.is_new != exp_o.is_new) begin
						$error("is_new expected %0d actual %0d", exp_o.is_new, got.is_new);
						n_errors++;
					end
					if (got.table_full != exp_o.table_full) begin
						$error("table_full expected %0d actual %0d", exp_o.table_full,
							got.table_full);
						n_errors++;
					end
				end
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < 10) begin
				m_tready <= 1'b0;
				stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) :
					$urandom_range(8, 40);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// send one transaction, with an optional random gap before it
	task automatic send_word(input logic [31:0] w, input logic start, input bit gaps);
		int unsigned gap;
		gap = 0;
		if (gaps) begin
			gap = $urandom_range(0, 99);
			gap = gap < 70 ? 0 : (gap < 95 ? $urandom_range(1, 3) : $urandom_range(5, 30));
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		track_word(w, start);
	endtask

	task automatic send_row(input logic [31:0] r [N_COLS], input logic start, input bit gaps);
		for (int c = 0; c < N_COLS; c++) send_word(r[c], start && c == 0, gaps);
	endtask

	task automatic wait_drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outcome_q.size() != 0) @(posedge clk);
	endtask

	// directed rows: the fill word is repeated over the row, tweak goes in one column
	typedef struct {
		logic [31:0]  fill;
		logic [31:0]  tweak;
		int           tweak_col;
		logic         start;
		bit           typed;
		row_outcome_t outcome;
	} dir_row_t;

	dir_row_t dir_rows [] = '{
		'{POS_ZERO, POS_ZERO, 0, 1'b0, 1'b1, '{6'd0, 1'b1, 1'b0}},  // before any start
		'{POS_ZERO, POS_ZERO, 0, 1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}},  // start empties store
		'{NEG_ZERO, NEG_ZERO, 0, 1'b0, 1'b1, '{6'd0, 1'b0, 1'b0}},  // -0 == +0
		'{QNAN, QNAN, 0, 1'b0, 1'b1, '{6'd1, 1'b1, 1'b0}},          // NaN row always new
		'{QNAN, QNAN, 0, 1'b0, 1'b1, '{6'd2, 1'b1, 1'b0}},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0, 1'b1, '{6'd3, 1'b1, 1'b0}},
		'{POS_INF, POS_INF, 0, 1'b0, 1'b1, '{6'd4, 1'b1, 1'b0}},
		'{POS_INF, POS_INF, 0, 1'b0, 1'b1, '{6'd4, 1'b0, 1'b0}},
		'{POS_ZERO, 32'h0000_0001, N_COLS - 1, 1'b0, 1'b0, '0},  // last column differs
		'{POS_ZERO, 32'h0000_0001, N_COLS - 1, 1'b0, 1'b0, '0},
		'{32'h3F80_0000, 32'hBF80_0000, 0, 1'b0, 1'b0, '0},
		'{32'h3F80_0000, 32'h3F80_0000, 0, 1'b1, 1'b1, '{6'd0, 1'b1, 1'b0}}
	};

	initial begin
		logic [31:0] row [N_COLS];
		logic [31:0] pool [$];
		int unsigned n_items;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		m_tready = 1'b0;
		n_errors = 0;
		n_cycles = 0;
		shadow_count = 0;
		shadow_col = 0;
		foreach (shadow_match[k]) shadow_match[k] = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no gaps; typed rows are checked against the table too
		foreach (dir_rows[i]) begin
			foreach (row[c]) row[c] = dir_rows[i].fill;
			row[dir_rows[i].tweak_col] = dir_rows[i].tweak;
			send_row(row, dir_rows[i].start, 1'b0);
			if (dir_rows[i].typed && outcome_q[$] != dir_rows[i].outcome) begin
				$error("directed row %0d outcome expected %h actual %h", i,
					dir_rows[i].outcome, outcome_q[$]);
				n_errors++;
			end
		end

		// start mark mid-row drops the partial row
		for (int c = 0; c < 7; c++) send_word($urandom, 1'b0, 1'b0);
		foreach (row[c]) row[c] = $urandom;
		send_row(row, 1'b1, 1'b0);
		send_row(row, 1'b0, 1'b0);
		wait_drain();

		// fill the store past MAX_UNIQUE to hit table_full, then hit the top id
		foreach (row[c]) row[c] = c;
		for (int r = 0; r < N_UNIQUE + 2; r++) begin
			row[0] = r;
			send_row(row, r == 0, 1'b1);
		end
		row[0] = N_UNIQUE - 1;
		send_row(row, 1'b0, 1'b1);
		wait_drain();

		// random phase: rows drawn from a small pool so repeats are common
		n_items = 0;
		while (n_items < 900) begin
			int unsigned kind;
			kind = $urandom_range(0, 99);
			if (kind < 4) begin
				// noise: partial row then restart
				repeat ($urandom_range(1, N_COLS - 1)) begin
					send_word($urandom, 1'b0, 1'b1);
					n_items++;
				end
				pool.delete();
				foreach (row[c]) row[c] = $urandom;
				send_row(row, 1'b1, 1'b1);
			end else begin
				if (pool.size() >= N_COLS && kind < 60) begin
					foreach (row[c]) row[c] = pool[c];
					if (kind < 20) row[$urandom_range(0, N_COLS - 1)] ^= 32'h8000_0000;
					if (kind < 8) row[$urandom_range(0, N_COLS - 1)] = QNAN | $urandom_range(0, 7);
				end else begin
					foreach (row[c])
						row[c] = ($urandom_range(0, 3) == 0) ? POS_ZERO : $urandom;
					pool.delete();
					foreach (row[c]) pool.push_back(row[c]);
				end
				send_row(row, 1'b0, 1'b1);
			end
			n_items += N_COLS;
			if (n_items % 300 < N_COLS) wait_drain();
		end

		wait_drain();
		repeat (20) @(posedge clk);
		if (n_errors == 0 && outcome_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/rdi_pkg.sv
hw/rtl/rdi_cell.sv
hw/rtl/row_dedup_id_assigner.sv
test/tb_top.sv
